>>> rtl/sspq_pkg.sv
// ---------------------------------------------------------------------------
// sspq_pkg
// Shared sizes, request codes and entry type of the stable sorted queue.
// ---------------------------------------------------------------------------
package sspq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 9;

    localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

endpackage

>>> rtl/sspq_if.sv
// ---------------------------------------------------------------------------
// sspq request and response channels
// Valid/ready channels carrying queue requests and their results.
// ---------------------------------------------------------------------------
interface sspq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [sspq_pkg::KEY_BITS-1:0]      entry_key;
    logic [sspq_pkg::HANDLE_BITS-1:0]   entry_handle;

    modport source (output valid, output req_type, output entry_key,
                    output entry_handle, input ready);
    modport sink   (input valid, input req_type, input entry_key,
                    input entry_handle, output ready);
endinterface

interface sspq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [sspq_pkg::HANDLE_BITS-1:0]   out_handle;
    logic [sspq_pkg::KEY_BITS-1:0]      out_key;
    logic                               was_empty;
    logic                               was_full;
    logic [sspq_pkg::COUNT_BITS-1:0]    queue_count;

    modport source (output valid, output out_handle, output out_key,
                    output was_empty, output was_full, output queue_count,
                    input ready);
    modport sink   (input valid, input out_handle, input out_key,
                    input was_empty, input was_full, input queue_count,
                    output ready);
endinterface

>>> rtl/sspq_ram.sv
// ---------------------------------------------------------------------------
// sspq_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module sspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/stable_sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue
// Min-first queue held in ascending key order, ties leave in arrival order.
// ---------------------------------------------------------------------------
// usage
//   req channel: req_type selects insert (entry_key, entry_handle) or remove
//   of the smallest entry. rsp channel: exactly one transaction per request,
//   with the removed entry or zeros, the empty/full flags and the new count.
//   entries live in one ring buffer memory; head points at the smallest.
//   remove: when non-empty, reads the head slot and takes the entry in ST_REM_WAIT.
//   insert: walks from the tail towards the head, one memory read and one
//   write per cycle, moving each larger entry up one slot, then writes the
//   new entry into the slot left free. insert into an empty queue, empty
//   remove and full insert are answered straight from ST_IDLE.
//   one request is worked on at a time; the memory read port sets the pace.
//   the result sits in an output register; req.ready stays low while that
//   register is occupied and not being taken, so a stalled receiver holds
//   the queue. reset empties the queue at once (count and head cleared,
//   memory contents are left as they are).
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    sspq_req_if.sink    req,
    sspq_rsp_if.source  rsp
);

    localparam int DEPTH      = sspq_pkg::QUEUE_DEPTH;
    localparam int ADDR_BITS  = sspq_pkg::ADDR_BITS;
    localparam int COUNT_BITS = sspq_pkg::COUNT_BITS;
    localparam int SUM_BITS   = ADDR_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM_WAIT,
        ST_INS_CMP,
        ST_INS_LAST
    } state_t;

    state_t                              state_reg, state_next;
    logic [ADDR_BITS-1:0]                head_reg, head_next;
    logic [COUNT_BITS-1:0]               count_reg, count_next;
    logic [ADDR_BITS-1:0]                ptr_reg, ptr_next;
    logic [ADDR_BITS-1:0]                rem_reg, rem_next;
    logic [sspq_pkg::KEY_BITS-1:0]       key_reg, key_next;
    logic [sspq_pkg::HANDLE_BITS-1:0]    handle_reg, handle_next;

    logic                                rsp_valid_reg, rsp_valid_next;
    logic [sspq_pkg::HANDLE_BITS-1:0]    out_handle_reg, out_handle_next;
    logic [sspq_pkg::KEY_BITS-1:0]       out_key_reg, out_key_next;
    logic                                was_empty_reg, was_empty_next;
    logic                                was_full_reg, was_full_next;
    logic [COUNT_BITS-1:0]               queue_count_reg, queue_count_next;

    logic                                mem_we;
    logic [ADDR_BITS-1:0]                mem_waddr;
    sspq_pkg::entry_t                    mem_wdata;
    logic [ADDR_BITS-1:0]                mem_raddr;
    sspq_pkg::entry_t                    mem_rdata;

    logic                                req_fire;
    logic [SUM_BITS-1:0]                 tail_sum;
    logic [ADDR_BITS-1:0]                tail_addr;
    logic [ADDR_BITS-1:0]                ptr_inc;
    logic [ADDR_BITS-1:0]                ptr_dec;
    logic [ADDR_BITS-1:0]                head_inc;
    sspq_pkg::entry_t                    new_entry;

    sspq_ram #(
        .WIDTH (sspq_pkg::ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;

    // physical slot of the last (largest) entry, wrapped round the ring
    assign tail_sum  = SUM_BITS'(head_reg) + SUM_BITS'(count_reg - COUNT_BITS'(1));
    assign tail_addr = (tail_sum >= SUM_BITS'(DEPTH))
                     ? ADDR_BITS'(tail_sum - SUM_BITS'(DEPTH))
                     : ADDR_BITS'(tail_sum);

    assign ptr_inc  = (ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : ptr_reg + ADDR_BITS'(1);
    assign ptr_dec  = (ptr_reg == '0) ? ADDR_BITS'(DEPTH - 1) : ptr_reg - ADDR_BITS'(1);
    assign head_inc = (head_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : head_reg + ADDR_BITS'(1);

    assign new_entry.key    = key_reg;
    assign new_entry.handle = handle_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        rem_next         = rem_reg;
        key_next         = key_reg;
        handle_next      = handle_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        out_handle_next  = out_handle_reg;
        out_key_next     = out_key_reg;
        was_empty_next   = was_empty_reg;
        was_full_next    = was_full_reg;
        queue_count_next = queue_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = new_entry;
        mem_raddr        = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    key_next        = req.entry_key;
                    handle_next     = req.entry_handle;
                    out_handle_next = '0;
                    out_key_next    = '0;
                    was_empty_next  = 1'b0;
                    was_full_next   = 1'b0;
                    if (req.req_type == sspq_pkg::REQ_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_valid_next   = 1'b1;
                            was_empty_next   = 1'b1;
                            queue_count_next = count_reg;
                        end
                        else
                        begin
                            mem_raddr  = head_reg;
                            state_next = ST_REM_WAIT;
                        end
                    end
                    else if (count_reg == COUNT_BITS'(DEPTH))
                    begin
                        rsp_valid_next   = 1'b1;
                        was_full_next    = 1'b1;
                        queue_count_next = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = head_reg;
                        mem_wdata.key    = req.entry_key;
                        mem_wdata.handle = req.entry_handle;
                        count_next       = count_reg + COUNT_BITS'(1);
                        rsp_valid_next   = 1'b1;
                        queue_count_next = count_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        mem_raddr  = tail_addr;
                        ptr_next   = tail_addr;
                        rem_next   = ADDR_BITS'(count_reg - COUNT_BITS'(1));
                        state_next = ST_INS_CMP;
                    end
                end
            end

            ST_REM_WAIT:
            begin
                out_handle_next  = mem_rdata.handle;
                out_key_next     = mem_rdata.key;
                head_next        = head_inc;
                count_next       = count_reg - COUNT_BITS'(1);
                queue_count_next = count_reg - COUNT_BITS'(1);
                rsp_valid_next   = 1'b1;
                state_next       = ST_IDLE;
            end

            ST_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_inc;
                if (mem_rdata.key > key_reg)
                begin
                    // larger entry moves up one slot
                    mem_wdata = mem_rdata;
                    if (rem_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        mem_raddr = ptr_dec;
                        ptr_next  = ptr_dec;
                        rem_next  = rem_reg - ADDR_BITS'(1);
                    end
                end
                else
                begin
                    // equal or smaller key found, new entry goes just above it
                    mem_wdata        = new_entry;
                    count_next       = count_reg + COUNT_BITS'(1);
                    queue_count_next = count_reg + COUNT_BITS'(1);
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_INS_LAST:
            begin
                mem_we           = 1'b1;
                mem_waddr        = ptr_reg;
                mem_wdata        = new_entry;
                count_next       = count_reg + COUNT_BITS'(1);
                queue_count_next = count_reg + COUNT_BITS'(1);
                rsp_valid_next   = 1'b1;
                state_next       = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            ptr_reg         <= '0;
            rem_reg         <= '0;
            key_reg         <= '0;
            handle_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            out_handle_reg  <= '0;
            out_key_reg     <= '0;
            was_empty_reg   <= 1'b0;
            was_full_reg    <= 1'b0;
            queue_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            rem_reg         <= rem_next;
            key_reg         <= key_next;
            handle_reg      <= handle_next;
            rsp_valid_reg   <= rsp_valid_next;
            out_handle_reg  <= out_handle_next;
            out_key_reg     <= out_key_next;
            was_empty_reg   <= was_empty_next;
            was_full_reg    <= was_full_next;
            queue_count_reg <= queue_count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_handle  = out_handle_reg;
    assign rsp.out_key     = out_key_reg;
    assign rsp.was_empty   = was_empty_reg;
    assign rsp.was_full    = was_full_reg;
    assign rsp.queue_count = queue_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("entry count beyond capacity");

    a_walk_inside : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_CMP) |-> (COUNT_BITS'(rem_reg) < count_reg))
        else $error("insert walk runs past the stored entries");

    a_remove_result : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REM_WAIT) |=> (rsp.valid && !rsp.was_empty
                                        && (count_reg == $past(count_reg) - COUNT_BITS'(1))))
        else $error("remove did not deliver one entry");

    a_full_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.was_full) |-> (rsp.queue_count == COUNT_BITS'(DEPTH)))
        else $error("full flag with free space");

    a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.was_empty) |-> (rsp.queue_count == '0 && rsp.out_key == '0))
        else $error("empty flag with stored entries");
`endif

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the stable sorted priority queue. Inserts and
// removes are pushed over the request channel with random gaps; a local
// sorted copy of the queue predicts each response, and a monitor compares
// every response field by field. Covers empty and full cases, key ties,
// extreme keys and handles, back-to-back traffic and a stalled receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 80;

    typedef struct {
        logic [sspq_pkg::HANDLE_BITS-1:0] handle;
        logic [sspq_pkg::KEY_BITS-1:0]    key;
        logic                             empty;
        logic                             full;
        logic [sspq_pkg::COUNT_BITS-1:0]  count;
    } queue_result_t;

    logic clk;
    logic rst_n;

    sspq_req_if req_ch ();
    sspq_rsp_if rsp_ch ();

    stable_sorted_priority_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sspq_pkg::entry_t sorted_entries[$];
    queue_result_t    pending_results[$];
    int               error_count;
    int               stalled_cycles;
    bit               idle_enable;
    bit               hold_rsp;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // predictor: ascending list, new entry goes after all equal keys
    // ---------------------------------------------------------------------
    function automatic queue_result_t predict_request(
        input logic                             kind,
        input logic [sspq_pkg::KEY_BITS-1:0]    key,
        input logic [sspq_pkg::HANDLE_BITS-1:0] handle);
        queue_result_t    res;
        sspq_pkg::entry_t ent;
        int               pos;
        res.handle = '0;
        res.key    = '0;
        res.empty  = 1'b0;
        res.full   = 1'b0;
        if (kind == sspq_pkg::REQ_INSERT)
        begin
            if (sorted_entries.size() >= sspq_pkg::QUEUE_DEPTH)
                res.full = 1'b1;
            else
            begin
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos].key <= key)
                    pos++;
                ent.key    = key;
                ent.handle = handle;
                sorted_entries.insert(pos, ent);
            end
        end
        else
        begin
            if (sorted_entries.size() == 0)
                res.empty = 1'b1;
            else
            begin
                ent        = sorted_entries.pop_front();
                res.key    = ent.key;
                res.handle = ent.handle;
            end
        end
        res.count = sspq_pkg::COUNT_BITS'(sorted_entries.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------
    task automatic send_request(input logic                             kind,
                                input logic [sspq_pkg::KEY_BITS-1:0]    key,
                                input logic [sspq_pkg::HANDLE_BITS-1:0] handle);
        int gap;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.entry_key    <= key;
        req_ch.entry_handle <= handle;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_request(kind, key, handle));
    endtask

    // mix of inserts and removes, keys often clustered to force ties
    task automatic send_random_item(input int insert_pct);
        logic [sspq_pkg::KEY_BITS-1:0] key;
        logic                          kind;
        case ($urandom_range(0, 3))
            0:       key = sspq_pkg::KEY_BITS'($urandom_range(0, 7));
            1:       key = '1 - sspq_pkg::KEY_BITS'($urandom_range(0, 3));
            default: key = sspq_pkg::KEY_BITS'($urandom);
        endcase
        kind = ($urandom_range(1, 100) <= insert_pct) ? sspq_pkg::REQ_INSERT
                                                       : sspq_pkg::REQ_REMOVE;
        send_request(kind, key, sspq_pkg::HANDLE_BITS'($urandom_range(0, 511)));
    endtask

    // ---------------------------------------------------------------------
    // response side: random stalls, with one long hold-off
    // ---------------------------------------------------------------------
    initial
    begin
        int gap;
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            gap = idle_enable ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no request pending", 64'd1, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.out_handle !== want.handle)
                    report_mismatch("out_handle", 64'(rsp_ch.out_handle),
                                    64'(want.handle));
                if (rsp_ch.out_key !== want.key)
                    report_mismatch("out_key", 64'(rsp_ch.out_key), 64'(want.key));
                if (rsp_ch.was_empty !== want.empty)
                    report_mismatch("was_empty", 64'(rsp_ch.was_empty), 64'(want.empty));
                if (rsp_ch.was_full !== want.full)
                    report_mismatch("was_full", 64'(rsp_ch.was_full), 64'(want.full));
                if (rsp_ch.queue_count !== want.count)
                    report_mismatch("queue_count", 64'(rsp_ch.queue_count),
                                    64'(want.count));
            end
        end
    end

    // no transaction on either channel for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n)
            stalled_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog expired", $realtime);
            $display("** stable_sorted_priority_queue: FAILED **");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    task automatic test_corner_cases();
        send_request(sspq_pkg::REQ_REMOVE, '1, '1);
        send_request(sspq_pkg::REQ_INSERT, '1, '1);
        send_request(sspq_pkg::REQ_INSERT, '0, '0);
        send_request(sspq_pkg::REQ_INSERT, 32'd5, 9'h0AA);
        send_request(sspq_pkg::REQ_INSERT, 32'd5, 9'h155);
        send_request(sspq_pkg::REQ_INSERT, 32'd5, 9'h003);
        send_request(sspq_pkg::REQ_INSERT, '1, 9'h100);
        send_request(sspq_pkg::REQ_INSERT, '0, 9'h1FE);
        send_request(sspq_pkg::REQ_INSERT, 32'd6, 9'h0F0);
        send_request(sspq_pkg::REQ_INSERT, 32'd4, 9'h00F);
        repeat (10)
            send_request(sspq_pkg::REQ_REMOVE, sspq_pkg::KEY_BITS'($urandom),
                         sspq_pkg::HANDLE_BITS'($urandom_range(0, 511)));
    endtask

    // fill to capacity, try to overflow, then drain past empty
    task automatic test_fill_and_overflow();
        logic [sspq_pkg::KEY_BITS-1:0] key;
        repeat (sspq_pkg::QUEUE_DEPTH)
        begin
            key = $urandom_range(0, 1) ? sspq_pkg::KEY_BITS'($urandom_range(0, 15))
                                       : sspq_pkg::KEY_BITS'($urandom);
            send_request(sspq_pkg::REQ_INSERT, key,
                         sspq_pkg::HANDLE_BITS'($urandom_range(0, 511)));
        end
        send_request(sspq_pkg::REQ_INSERT, '0, '0);
        send_request(sspq_pkg::REQ_INSERT, '1, '1);
        send_request(sspq_pkg::REQ_INSERT, sspq_pkg::KEY_BITS'($urandom),
                     sspq_pkg::HANDLE_BITS'($urandom_range(0, 511)));
        repeat (sspq_pkg::QUEUE_DEPTH + 1)
            send_request(sspq_pkg::REQ_REMOVE, sspq_pkg::KEY_BITS'($urandom),
                         sspq_pkg::HANDLE_BITS'($urandom_range(0, 511)));
    endtask

    task automatic test_random_mix();
        repeat (40)
            send_random_item(65);
        repeat (40)
            send_random_item(40);
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        repeat (30)
            send_random_item(55);
        idle_enable = 1'b1;
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_stalled_receiver();
        hold_rsp = 1'b1;
        repeat (16)
            send_random_item(60);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        idle_enable         = 1'b1;
        hold_rsp            = 1'b0;
        error_count         = 0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = sspq_pkg::REQ_INSERT;
        req_ch.entry_key    = '0;
        req_ch.entry_handle = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_fill_and_overflow();
        test_random_mix();
        test_back_to_back();
        test_stalled_receiver();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** stable_sorted_priority_queue: PASSED **");
        else
            $display("** stable_sorted_priority_queue: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/sspq_pkg.sv
rtl/sspq_if.sv
rtl/sspq_ram.sv
rtl/stable_sorted_priority_queue.sv
test/tb.sv
